[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the placer RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define FLP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Check that a condition in one cycle implies another in the next cycle.
`define FLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FLP_ASSERT(lbl, clk, rst, prop)
`define FLP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/flp_pkg.sv]
// ----------------------------------------------------------------------------
// flp_pkg
// Shared types, constants and helpers of the flow layout placer.
// ----------------------------------------------------------------------------
package flp_pkg;

  localparam logic [23:0] SIZE_LIMIT = 24'd16777215;
  localparam logic [24:0] CUR_MAX    = 25'h1FFFFFF;
  localparam int unsigned CFG_W      = 25;
  localparam int unsigned IDX_W      = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_MAIN_AXIS,
    REG_WRAP_MODE,
    REG_BOX_GAP,
    REG_ROW_GAP,
    REG_AREA_LEFT,
    REG_AREA_TOP,
    REG_AREA_WIDTH,
    REG_AREA_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic               main_axis;
    logic               wrap_mode;
    logic [15:0]        box_gap;
    logic [15:0]        row_gap;
    logic signed [24:0] area_left;
    logic signed [24:0] area_top;
    logic [23:0]        area_width;
    logic [23:0]        area_height;
  } cfg_t;

  // One classified box: sizes already clamped and mapped to along/across.
  typedef struct packed {
    logic [23:0] size_al;
    logic [23:0] size_ac;
    logic        last;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_rd_t;

  // Along-axis capacity of one row.
  function automatic logic [23:0] row_cap(input cfg_t c);
    logic [23:0] area_al;
    area_al = c.main_axis ? c.area_height : c.area_width;
    return c.wrap_mode ? area_al : SIZE_LIMIT;
  endfunction

  function automatic logic [23:0] max24(input logic [23:0] a, input logic [23:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [23:0] min24(input logic [23:0] a, input logic [23:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

[rtl/flp_front.sv]
// ----------------------------------------------------------------------------
// flp_front
// Accept input words, clamp the box sizes and map them to along/across.
// ----------------------------------------------------------------------------
module flp_front (
  input  flp_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [23:0]    pref_width,
  input  logic [23:0]    pref_height,
  input  logic [23:0]    least_width,
  input  logic [23:0]    least_height,
  input  logic [23:0]    most_width,
  input  logic [23:0]    most_height,
  input  logic           last_in,
  input  logic           q_full,
  output flp_pkg::q_wr_t wr
);
  import flp_pkg::*;

  logic        vert;
  logic [23:0] pref_al, pref_ac, least_al, least_ac, most_ac, area_ac, cap;

  always_comb begin
    vert     = cfg.main_axis;
    pref_al  = vert ? pref_height  : pref_width;
    pref_ac  = vert ? pref_width   : pref_height;
    least_al = vert ? least_height : least_width;
    least_ac = vert ? least_width  : least_height;
    most_ac  = vert ? most_width   : most_height;
    area_ac  = vert ? cfg.area_width : cfg.area_height;
    cap      = row_cap(cfg);

    in_ready          = !q_full;
    wr.push           = in_valid && !q_full;
    wr.item.size_al   = max24(least_al, min24(pref_al, cap));
    wr.item.size_ac   = cfg.wrap_mode ? pref_ac : max24(least_ac, min24(most_ac, area_ac));
    wr.item.last      = last_in;
  end

endmodule

[rtl/flp_queue.sv]
// ----------------------------------------------------------------------------
// flp_queue
// Two-entry queue between the classifying front and the placing back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flp_queue (
  input  logic           clk,
  input  logic           rst,
  input  flp_pkg::q_wr_t wr,
  output logic           full,
  output flp_pkg::q_rd_t rd,
  input  logic           pop
);
  import flp_pkg::*;

  item_t      slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd.valid = (count != 2'd0);
  assign rd.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr.push) wr_ptr <= !wr_ptr;
      if (pop)     rd_ptr <= !rd_ptr;
      case ({wr.push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) slots[wr_ptr] <= wr.item;
  end

  `FLP_ASSERT(a_q_bound, clk, rst, count <= 2'd2)
  `FLP_ASSERT_NEXT(a_q_fill, clk, rst, wr.push && !pop, count == $past(count) + 2'd1)

endmodule

[rtl/flp_back.sv]
// ----------------------------------------------------------------------------
// flp_back
// Run the row cursors, place each box and hold the result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flp_back (
  input  logic                clk,
  input  logic                rst,
  input  flp_pkg::cfg_t       cfg,
  input  flp_pkg::q_rd_t      rd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [25:0]  box_x,
  output logic signed [25:0]  box_y,
  output logic [23:0]         box_width,
  output logic [23:0]         box_height,
  output logic [24:0]         total_width,
  output logic [24:0]         total_height,
  output logic                last_out
);
  import flp_pkg::*;

  // Saturating origin plus offset; the sum can only overflow upward.
  function automatic logic signed [25:0] place(input logic signed [24:0] org,
                                               input logic [24:0] off);
    logic signed [26:0] s;
    s = $signed({{2{org[24]}}, org}) + $signed({2'b00, off});
    return (s > 27'sd33554431) ? 26'sh1FFFFFF : s[25:0];
  endfunction

  logic [24:0] along, across, widest;
  logic [23:0] rdm;
  logic        has;

  logic        take, vert, do_wrap;
  logic [23:0] cap;
  logic [25:0] fit_sum, gap_sum, end_sum, tot_sum;
  logic [26:0] row_sum;
  logic [24:0] along_gap, across_row, start_al, base_ac, base_widest, along_next;
  logic [24:0] tot_al, tot_ac;
  logic [23:0] base_rdm, rdm_next;
  logic signed [25:0] pos_al, pos_ac;

  always_comb begin
    take    = rd.valid && (!out_valid || out_ready);
    pop     = take;
    vert    = cfg.main_axis;
    cap     = row_cap(cfg);

    fit_sum = {1'b0, along} + {10'd0, cfg.box_gap} + {2'd0, rd.item.size_al};
    do_wrap = has && (fit_sum > {2'd0, cap});

    gap_sum    = {1'b0, along} + {10'd0, cfg.box_gap};
    along_gap  = gap_sum[25] ? CUR_MAX : gap_sum[24:0];
    row_sum    = {2'd0, across} + {3'd0, rdm} + {11'd0, cfg.row_gap};
    across_row = (|row_sum[26:25]) ? CUR_MAX : row_sum[24:0];

    start_al    = (do_wrap || !has) ? 25'd0 : along_gap;
    base_ac     = do_wrap ? across_row : across;
    base_rdm    = do_wrap ? 24'd0 : rdm;
    base_widest = (do_wrap && along > widest) ? along : widest;

    end_sum    = {1'b0, start_al} + {2'd0, rd.item.size_al};
    along_next = end_sum[25] ? CUR_MAX : end_sum[24:0];
    rdm_next   = max24(base_rdm, rd.item.size_ac);

    tot_al  = (along_next > base_widest) ? along_next : base_widest;
    tot_sum = {1'b0, base_ac} + {2'd0, rdm_next};
    tot_ac  = tot_sum[25] ? CUR_MAX : tot_sum[24:0];

    pos_al = place(vert ? cfg.area_top : cfg.area_left, start_al);
    pos_ac = place(vert ? cfg.area_left : cfg.area_top, base_ac);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      along     <= '0;
      across    <= '0;
      widest    <= '0;
      rdm       <= '0;
      has       <= 1'b0;
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
      if (rd.item.last) begin
        along  <= '0;
        across <= '0;
        widest <= '0;
        rdm    <= '0;
        has    <= 1'b0;
      end else begin
        along  <= along_next;
        across <= base_ac;
        widest <= base_widest;
        rdm    <= rdm_next;
        has    <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      box_x        <= vert ? pos_ac : pos_al;
      box_y        <= vert ? pos_al : pos_ac;
      box_width    <= vert ? rd.item.size_ac : rd.item.size_al;
      box_height   <= vert ? rd.item.size_al : rd.item.size_ac;
      total_width  <= rd.item.last ? (vert ? tot_ac : tot_al) : 25'd0;
      total_height <= rd.item.last ? (vert ? tot_al : tot_ac) : 25'd0;
      last_out     <= rd.item.last;
    end
  end

  `FLP_ASSERT_NEXT(a_clear_after_last, clk, rst, take && rd.item.last,
                   along == 25'd0 && across == 25'd0 && widest == 25'd0 && !has)
  `FLP_ASSERT(a_empty_row, clk, rst, !has |-> (along == 25'd0 && rdm == 24'd0))
  `FLP_ASSERT(a_totals_last, clk, rst,
              (out_valid && !last_out) |-> (total_width == 25'd0 && total_height == 25'd0))

endmodule

[rtl/flow_layout_placer.sv]
// ----------------------------------------------------------------------------
// flow_layout_placer
// Greedy flow layout: places a list of boxes in rows along a main axis.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid/in_ready) carries one box word: preferred,
//   minimum and maximum size plus last_in marking the end of a list.
//   Output channel (out_valid/out_ready) returns one placed rectangle word
//   per box, in order; the word for the last box also carries the total
//   occupied size, and the row state clears for the next list.
//   Configuration goes through cfg_write/cfg_index/cfg_data, one register
//   per write, taken at once; write only while no box is in flight.
// Timing:
//   One word per cycle sustained while out_ready stays high. An accepted
//   input word enters the queue at the accepting edge, and the placing
//   stage then registers its result and raises out_valid. The cursor
//   update in the back stage, computed combinationally, sets the rate.
// Reset:
//   rst (synchronous) empties the queue, drops out_valid, clears the row
//   cursors and loads register defaults (vertical axis, no wrap, zeros).
// Stall:
//   While out_ready is low the result word holds; the two-entry queue
//   absorbs the words in flight, then in_ready drops until space frees.
// ----------------------------------------------------------------------------
module flow_layout_placer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [flp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [flp_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [23:0]                 pref_width,
  input  logic [23:0]                 pref_height,
  input  logic [23:0]                 least_width,
  input  logic [23:0]                 least_height,
  input  logic [23:0]                 most_width,
  input  logic [23:0]                 most_height,
  input  logic                        last_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [25:0]          box_x,
  output logic signed [25:0]          box_y,
  output logic [23:0]                 box_width,
  output logic [23:0]                 box_height,
  output logic [24:0]                 total_width,
  output logic [24:0]                 total_height,
  output logic                        last_out
);
  import flp_pkg::*;

  cfg_t  cfg;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Register file: each write lands immediately, narrowed to its field.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.main_axis   <= 1'b1;
      cfg.wrap_mode   <= 1'b0;
      cfg.box_gap     <= '0;
      cfg.row_gap     <= '0;
      cfg.area_left   <= '0;
      cfg.area_top    <= '0;
      cfg.area_width  <= '0;
      cfg.area_height <= '0;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_MAIN_AXIS:   cfg.main_axis   <= cfg_data[0];
        REG_WRAP_MODE:   cfg.wrap_mode   <= cfg_data[0];
        REG_BOX_GAP:     cfg.box_gap     <= cfg_data[15:0];
        REG_ROW_GAP:     cfg.row_gap     <= cfg_data[15:0];
        REG_AREA_LEFT:   cfg.area_left   <= $signed(cfg_data[24:0]);
        REG_AREA_TOP:    cfg.area_top    <= $signed(cfg_data[24:0]);
        REG_AREA_WIDTH:  cfg.area_width  <= cfg_data[23:0];
        REG_AREA_HEIGHT: cfg.area_height <= cfg_data[23:0];
        default:         cfg.main_axis   <= cfg.main_axis;
      endcase
    end
  end

  // Front: clamp sizes and push classified words into the queue.
  flp_front u_front (
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pref_width   (pref_width),
    .pref_height  (pref_height),
    .least_width  (least_width),
    .least_height (least_height),
    .most_width   (most_width),
    .most_height  (most_height),
    .last_in      (last_in),
    .q_full       (q_full),
    .wr           (q_wr)
  );

  // Queue: decouple front acceptance from back-side stalls.
  flp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .full (q_full),
    .rd   (q_rd),
    .pop  (q_pop)
  );

  // Back: advance cursors, wrap rows, place the box and hold the result.
  flp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .rd           (q_rd),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .box_x        (box_x),
    .box_y        (box_y),
    .box_width    (box_width),
    .box_height   (box_height),
    .total_width  (total_width),
    .total_height (total_height),
    .last_out     (last_out)
  );

endmodule

[dv/tb_flow_layout_placer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flow_layout_placer
// Self-checking bench for the flow layout placer. Boxes go in through the
// valid/ready input channel. A cycle-free predictor keeps its own copy of
// the row cursors and of the register file. Every placed word coming out is
// checked field by field against the oldest prediction. A directed opening
// covers the edge cases: extremes, oversized boxes, saturation, and a
// register change in the middle of a list. Randomized phases follow, each
// under its own setting, all but the last with idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_flow_layout_placer;
  import flp_pkg::*;

  // One box as offered on the input channel.
  typedef struct {
    logic [23:0] pref_w;
    logic [23:0] pref_h;
    logic [23:0] least_w;
    logic [23:0] least_h;
    logic [23:0] most_w;
    logic [23:0] most_h;
    logic        last;
    bit          drain;  // hold this word back until every result is in
  } box_t;

  // One placed rectangle as expected on the output channel.
  typedef struct {
    logic [25:0] x;
    logic [25:0] y;
    logic [23:0] w;
    logic [23:0] h;
    logic [24:0] tot_w;
    logic [24:0] tot_h;
    logic        last;
  } place_t;

  localparam int unsigned STUCK_LIMIT = 5000;  // cycles without any transfer
  localparam int unsigned LONG_HOLD   = 60;    // receiver back-pressure stretch
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_BOXES = 175;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               cfg_write    = 1'b0;
  logic [IDX_W-1:0]   cfg_index    = '0;
  logic [CFG_W-1:0]   cfg_data     = '0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [23:0]        pref_width   = '0;
  logic [23:0]        pref_height  = '0;
  logic [23:0]        least_width  = '0;
  logic [23:0]        least_height = '0;
  logic [23:0]        most_width   = '0;
  logic [23:0]        most_height  = '0;
  logic               last_in      = 1'b0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic signed [25:0] box_x;
  logic signed [25:0] box_y;
  logic [23:0]        box_width;
  logic [23:0]        box_height;
  logic [24:0]        total_width;
  logic [24:0]        total_height;
  logic               last_out;

  flow_layout_placer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pref_width   (pref_width),
    .pref_height  (pref_height),
    .least_width  (least_width),
    .least_height (least_height),
    .most_width   (most_width),
    .most_height  (most_height),
    .last_in      (last_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .box_x        (box_x),
    .box_y        (box_y),
    .box_width    (box_width),
    .box_height   (box_height),
    .total_width  (total_width),
    .total_height (total_height),
    .last_out     (last_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  box_t        pending_boxes[$];    // boxes waiting for the driver
  place_t      expected_places[$];  // predicted words not yet seen
  box_t        shown_box;           // box currently on the input port
  int unsigned boxes_queued   = 0;
  int unsigned boxes_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  bit          calm           = 1'b0;  // no idling on either side when set

  // Predictor copy of the registers and of the row cursors.
  cfg_t        setup;
  logic [24:0] al_cursor  = '0;
  logic [24:0] ac_cursor  = '0;
  logic [24:0] widest_run = '0;
  logic [23:0] row_depth  = '0;
  logic        row_open   = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Clamp a cursor sum to the 25-bit ceiling.
  function automatic logic [24:0] clip_cur(logic [26:0] v);
    return (v > {2'b00, CUR_MAX}) ? CUR_MAX : v[24:0];
  endfunction

  // Signed origin plus unsigned offset, saturated to 26-bit signed.
  function automatic logic [25:0] offset_coord(logic [24:0] origin, logic [24:0] offset);
    logic signed [27:0] c;
    c = {{3{origin[24]}}, origin} + {3'b000, offset};
    if (c > 28'sd33554431) return 26'h1FFFFFF;
    if (c < -28'sd33554432) return 26'h2000000;
    return c[25:0];
  endfunction

  // Place one box: advance the cursors and build the expected word.
  function automatic place_t place_box(box_t b);
    place_t      p;
    logic        vert;
    logic        wrap;
    logic [23:0] pref_al, pref_ac, least_al, least_ac, most_ac;
    logic [23:0] area_al, area_ac, cap, fit_al, fit_ac, size_al, size_ac;
    logic [24:0] org_al, org_ac, tot_al, tot_ac;
    logic [25:0] pos_al, pos_ac;
    vert     = setup.main_axis;
    wrap     = setup.wrap_mode;
    pref_al  = vert ? b.pref_h : b.pref_w;
    pref_ac  = vert ? b.pref_w : b.pref_h;
    least_al = vert ? b.least_h : b.least_w;
    least_ac = vert ? b.least_w : b.least_h;
    most_ac  = vert ? b.most_w : b.most_h;
    area_al  = vert ? setup.area_height : setup.area_width;
    area_ac  = vert ? setup.area_width : setup.area_height;
    org_al   = vert ? setup.area_top : setup.area_left;
    org_ac   = vert ? setup.area_left : setup.area_top;

    // Along: preferred clipped to the row, but the minimum always wins.
    cap     = wrap ? area_al : SIZE_LIMIT;
    fit_al  = (pref_al < cap) ? pref_al : cap;
    size_al = (least_al > fit_al) ? least_al : fit_al;
    // Across: preferred when wrapping, else the area clamped by min/max.
    fit_ac  = (most_ac < area_ac) ? most_ac : area_ac;
    size_ac = wrap ? pref_ac : ((least_ac > fit_ac) ? least_ac : fit_ac);

    // Start a new row when a non-empty row would overflow the capacity.
    if (row_open && ({2'b00, al_cursor} + 27'(setup.box_gap) + 27'(size_al) > 27'(cap)))
    begin
      if (al_cursor > widest_run) widest_run = al_cursor;
      ac_cursor = clip_cur({2'b00, ac_cursor} + 27'(row_depth) + 27'(setup.row_gap));
      al_cursor = '0;
      row_depth = '0;
      row_open  = 1'b0;
    end
    if (row_open) al_cursor = clip_cur({2'b00, al_cursor} + 27'(setup.box_gap));

    pos_al = offset_coord(org_al, al_cursor);
    pos_ac = offset_coord(org_ac, ac_cursor);

    al_cursor = clip_cur({2'b00, al_cursor} + 27'(size_al));
    if (size_ac > row_depth) row_depth = size_ac;
    row_open = 1'b1;

    p.x     = vert ? pos_ac : pos_al;
    p.y     = vert ? pos_al : pos_ac;
    p.w     = vert ? size_ac : size_al;
    p.h     = vert ? size_al : size_ac;
    p.tot_w = '0;
    p.tot_h = '0;
    p.last  = b.last;

    // Last box: report the occupied size, then start the next list fresh.
    if (b.last) begin
      tot_al     = (widest_run > al_cursor) ? widest_run : al_cursor;
      tot_ac     = clip_cur({2'b00, ac_cursor} + 27'(row_depth));
      p.tot_w    = vert ? tot_ac : tot_al;
      p.tot_h    = vert ? tot_al : tot_ac;
      al_cursor  = '0;
      ac_cursor  = '0;
      row_depth  = '0;
      row_open   = 1'b0;
      widest_run = '0;
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_box(input logic [23:0] pw, ph, lw, lh, mw, mh,
                                  input logic last);
    box_t b;
    b.pref_w  = pw;
    b.pref_h  = ph;
    b.least_w = lw;
    b.least_h = lh;
    b.most_w  = mw;
    b.most_h  = mh;
    b.last    = last;
    b.drain   = 1'b0;
    pending_boxes.push_back(b);
    boxes_queued++;
  endfunction

  function automatic cfg_t make_setup(logic axis, logic wrap, logic [15:0] igap,
                                      logic [15:0] rgap, int left, int top,
                                      logic [23:0] w, logic [23:0] h);
    cfg_t s;
    s.main_axis   = axis;
    s.wrap_mode   = wrap;
    s.box_gap     = igap;
    s.row_gap     = rgap;
    s.area_left   = 25'(left);
    s.area_top    = 25'(top);
    s.area_width  = w;
    s.area_height = h;
    return s;
  endfunction

  // Phase 0 takes every register at its top, phase 1 every register at zero but the area origins, which get -16777215.
  function automatic cfg_t rand_setup(int unsigned phase);
    if (phase == 0)
      return make_setup(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16777215, 16777215,
                        24'hFFFFFF, 24'hFFFFFF);
    if (phase == 1)
      return make_setup(1'b0, 1'b0, 16'h0000, 16'h0000, -16777215, -16777215,
                        24'h0, 24'h0);
    return make_setup(1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) != 0,
                      ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 8)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 8)),
                      int'($urandom_range(0, 33554430)) - 16777215,
                      int'($urandom_range(0, 33554430)) - 16777215,
                      ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 4095)),
                      ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 4095)));
  endfunction

  // Mostly sizes near the area scale, with zeros, full scale and raw noise.
  function automatic logic [23:0] rand_size(int unsigned span);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom());
      default: return 24'($urandom_range(0, span));
    endcase
  endfunction

  // Queue a phase; regular words end a list every 1..10, about one word in ten is noise with a random last flag.
  function automatic void fill_phase(int unsigned count, int unsigned span);
    box_t        b;
    int unsigned list_left;
    list_left = $urandom_range(1, 10);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        b.pref_w  = 24'($urandom());
        b.pref_h  = 24'($urandom());
        b.least_w = 24'($urandom());
        b.least_h = 24'($urandom());
        b.most_w  = 24'($urandom());
        b.most_h  = 24'($urandom());
        b.last    = 1'($urandom_range(0, 1));
      end else begin
        b.pref_w  = rand_size(span);
        b.pref_h  = rand_size(span);
        b.least_w = rand_size(span / 4);
        b.least_h = rand_size(span / 4);
        b.most_w  = rand_size(span * 2);
        b.most_h  = rand_size(span * 2);
        list_left--;
        b.last    = (list_left == 0);
        if (b.last) list_left = $urandom_range(1, 10);
      end
      // Once per phase make the sender wait for a full drain.
      b.drain = (i == count / 3);
      pending_boxes.push_back(b);
      boxes_queued++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration writes, only issued while the block is idle
  // --------------------------------------------------------------------------
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic apply_setup(cfg_t s);
    write_reg(REG_MAIN_AXIS,   25'(s.main_axis));
    write_reg(REG_WRAP_MODE,   25'(s.wrap_mode));
    write_reg(REG_BOX_GAP,     25'(s.box_gap));
    write_reg(REG_ROW_GAP,     25'(s.row_gap));
    write_reg(REG_AREA_LEFT,   25'(s.area_left));
    write_reg(REG_AREA_TOP,    25'(s.area_top));
    write_reg(REG_AREA_WIDTH,  25'(s.area_width));
    write_reg(REG_AREA_HEIGHT, 25'(s.area_height));
    @(posedge clk);
    cfg_write <= 1'b0;
    setup = s;
  endtask

  // Wait until every queued box is in and every result is out, then let the pipeline settle.
  task automatic settle();
    while (boxes_accepted != boxes_queued || expected_places.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: present queued boxes, predict each one on acceptance
  // --------------------------------------------------------------------------
  int unsigned send_gap = 0;

  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        expected_places.push_back(place_box(shown_box));
        boxes_accepted++;
        offer = 1'b0;
      end
      // Hold the current word while it is not taken; otherwise pick the
      // next one, unless an idle burst is running or a drain is requested.
      if (!offer) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_boxes.size() != 0 &&
                     !(pending_boxes[0].drain && expected_places.size() != 0)) begin
          shown_box = pending_boxes.pop_front();
          pref_width   <= shown_box.pref_w;
          pref_height  <= shown_box.pref_h;
          least_width  <= shown_box.least_w;
          least_height <= shown_box.least_h;
          most_width   <= shown_box.most_w;
          most_height  <= shown_box.most_h;
          last_in      <= shown_box.last;
          offer = 1'b1;
          if (!calm && $urandom_range(0, 19) == 0) send_gap = $urandom_range(1, 12);
        end
      end
      in_valid <= offer;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each word against the oldest prediction, drive out_ready
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    place_t want;
    logic   ready_next;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_places.size() == 0) begin
          mismatches++;
          $error("placed word with no box pending");
        end else begin
          want = expected_places.pop_front();
          check_field("box_x",        $signed(want.x), box_x);
          check_field("box_y",        $signed(want.y), box_y);
          check_field("box_width",    want.w,          box_width);
          check_field("box_height",   want.h,          box_height);
          check_field("total_width",  want.tot_w,      total_width);
          check_field("total_height", want.tot_h,      total_height);
          check_field("last_out",     want.last,       last_out);
        end
        // Hold off for a long stretch twice so the input side backs up.
        if (results_seen == 300 || results_seen == 1000) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        hold_left  = $urandom_range(0, 11);
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready <= ready_next;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // --------------------------------------------------------------------------
  int unsigned stuck_cycles = 0;

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t        s;
    int unsigned span;
    setup = '0;
    setup.main_axis = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: vertical, no wrap, empty area. Zeros, all-ones
    // (the next box then wraps at the limit), and a minimum above the maximum.
    add_box(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0);
    add_box('1, '1, '1, '1, '1, '1, 1'b0);
    add_box(24'd100, 24'd200, 24'd300, 24'd400, 24'd5, 24'd6, 1'b1);
    settle();

    // Horizontal wrap into a narrow area with maximal gaps: boxes wider than
    // the area sit alone, preferred sizes clip to the row.
    apply_setup(make_setup(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, -16777215, 16777215,
                           24'd1000, 24'hFFFFFF));
    add_box(24'd50,   24'd30, 24'd5000, 24'd0, 24'd0, 24'd0, 1'b0);
    add_box(24'd50,   24'd30, 24'd4000, 24'd0, 24'd0, 24'd0, 1'b0);
    add_box(24'd300,  24'd10, 24'd0,    24'd0, 24'd0, 24'd0, 1'b0);
    add_box(24'd300,  24'd20, 24'd0,    24'd0, 24'd0, 24'd0, 1'b0);
    add_box(24'd2000, 24'd5,  24'd10,   24'd0, 24'd0, 24'd0, 1'b0);
    add_box(24'd0,    24'd0,  24'd0,    24'd0, 24'd0, 24'd0, 1'b0);
    settle();

    // Change every register but wrap mode with the list still open; the rows
    // carry over. Full-size boxes in a zero area drive the across cursor and
    // the placed x into saturation.
    apply_setup(make_setup(1'b1, 1'b1, 16'h0, 16'h0, 16777215, -16777215,
                           24'h0, 24'h0));
    add_box('1, 24'h0, 24'h0, '1, 24'h0, 24'h0, 1'b0);
    add_box('1, 24'h0, 24'h0, '1, 24'h0, 24'h0, 1'b0);
    add_box('1, 24'h0, 24'h0, '1, 24'h0, 24'h0, 1'b0);
    add_box('1, '1,    24'h0, '1, '1,    '1,    1'b0);
    add_box(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1);
    settle();

    // Random phases; the last one runs without idling on either side.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      s = rand_setup(phase);
      apply_setup(s);
      calm = (phase == PHASES - 1);
      span = ((s.area_width > s.area_height) ? s.area_width : s.area_height) / 3 + 8;
      if ($urandom_range(0, 3) == 0) span = 255;
      fill_phase(PHASE_BOXES, span);
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
